[rtl/lmf_pkg.sv]
`default_nettype none
// ----------------------------------------------------------------------------
// lmf_pkg: shared definitions of the label majority filter
// Label and window types, register codes, field widths and reset values.
// ----------------------------------------------------------------------------
package lmf_pkg;

    localparam int LABEL_W            = 2;
    localparam int NUM_CLASSES        = 3;
    localparam int COUNT_W            = 4;
    localparam int FRAME_WIDTH_W      = 11;
    localparam int FRAME_HEIGHT_W     = 16;
    localparam int CFG_DATA_W         = 16;
    localparam int CFG_INDEX_W        = 1;
    localparam int MAX_WIDTH_DEFAULT  = 1024;

    localparam logic [CFG_INDEX_W-1:0] REG_FRAME_WIDTH  = 1'd0;
    localparam logic [CFG_INDEX_W-1:0] REG_FRAME_HEIGHT = 1'd1;

    localparam logic [FRAME_WIDTH_W-1:0]  FRAME_WIDTH_RESET  = 11'd1024;
    localparam logic [FRAME_HEIGHT_W-1:0] FRAME_HEIGHT_RESET = 16'd1024;

    typedef logic [LABEL_W-1:0] label_t;

    // Indexed as [column: left, middle, right][row: top, middle, bottom].
    typedef label_t [2:0][2:0] window_t;

    typedef struct packed {
        logic left;
        logic right;
        logic top;
        logic bottom;
    } edge_t;

endpackage
`default_nettype wire

[rtl/lmf_if.sv]
`default_nettype none
// ----------------------------------------------------------------------------
// lmf_if: stream interfaces of the label majority filter
// One interface for incoming pixel words and one for result words.
// ----------------------------------------------------------------------------
interface lmf_pixel_if;
    logic             valid;
    logic             ready;
    lmf_pkg::label_t  pixel_label;
    logic             is_padding;

    modport source (output valid, output pixel_label, output is_padding, input ready);
    modport sink   (input valid, input pixel_label, input is_padding, output ready);
endinterface

interface lmf_result_if;
    logic             valid;
    logic             ready;
    lmf_pkg::label_t  smoothed_label;
    logic             last_pixel;

    modport source (output valid, output smoothed_label, output last_pixel, input ready);
    modport sink   (input valid, input smoothed_label, input last_pixel, output ready);
endinterface
`default_nettype wire

[rtl/lmf_ram.sv]
`default_nettype none
// ----------------------------------------------------------------------------
// lmf_ram: generic simple dual-port RAM
// One write port and one read port with registered read data.
// ----------------------------------------------------------------------------
module lmf_ram #(
    parameter int WIDTH = 4,
    parameter int DEPTH = 1024
) (
    input  wire logic                     clk,
    input  wire logic                     we,
    input  wire logic [$clog2(DEPTH)-1:0] waddr,
    input  wire logic [WIDTH-1:0]         wdata,
    input  wire logic                     re,
    input  wire logic [$clog2(DEPTH)-1:0] raddr,
    output      logic [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem [DEPTH];
    logic [WIDTH-1:0] rdata_reg;

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        if (re)
        begin
            rdata_reg <= mem[raddr];
        end
    end

    assign rdata = rdata_reg;

endmodule
`default_nettype wire

[rtl/lmf_vote.sv]
`default_nettype none
// ----------------------------------------------------------------------------
// lmf_vote: majority vote over a 3x3 label window
// Counts the in-frame labels per class and picks the most frequent class,
// the lowest class winning a tie.
// ----------------------------------------------------------------------------
module lmf_vote (
    input  wire lmf_pkg::window_t window,
    input  wire lmf_pkg::edge_t   edges,
    output      lmf_pkg::label_t  label
);

    logic [8:0]                   match [lmf_pkg::NUM_CLASSES];
    logic [lmf_pkg::COUNT_W-1:0]  cnt   [lmf_pkg::NUM_CLASSES];

    always_comb
    begin
        for (int k = 0; k < lmf_pkg::NUM_CLASSES; k++)
        begin
            for (int c = 0; c < 3; c++)
            begin
                for (int r = 0; r < 3; r++)
                begin
                    match[k][c*3+r] = !((c == 0 && !edges.left)  ||
                                        (c == 2 && !edges.right) ||
                                        (r == 0 && !edges.top)   ||
                                        (r == 2 && !edges.bottom)) &&
                                      (window[c][r] == lmf_pkg::LABEL_W'(k));
                end
            end
            cnt[k] = lmf_pkg::COUNT_W'($countones(match[k]));
        end
    end

    always_comb
    begin
        label = '0;
        for (int k = 1; k < lmf_pkg::NUM_CLASSES; k++)
        begin
            if (cnt[k] > cnt[label])
            begin
                label = lmf_pkg::LABEL_W'(k);
            end
        end
    end

endmodule
`default_nettype wire

[rtl/label_majority_filter_3x3.sv]
`default_nettype none
// ----------------------------------------------------------------------------
// label_majority_filter_3x3: 3x3 majority filter over a stream of class labels
// Two line stores in one RAM and a 3x3 window give the most frequent class of
// each pixel's in-frame neighborhood, results lagging one row plus one pixel.
//
//   Port   Role    Word
//   pix    sink    pixel_label, is_padding
//   res    source  smoothed_label, last_pixel
//   cfg    write   cfg_we, cfg_index, cfg_data
//
// One word is accepted per cycle unless the input stalls. A word passes the
// line-store read stage and then the vote into the result register.
// Reset clears the counters, the window and the valid flags; the line stores
// are not cleared. A stalled result holds the output register while one more
// word waits in the read stage; the input stalls only when both are full.
// ----------------------------------------------------------------------------
module label_majority_filter_3x3 #(
    parameter int MAX_WIDTH = lmf_pkg::MAX_WIDTH_DEFAULT
) (
    input  wire logic                            clk,
    input  wire logic                            rst_n,
    input  wire logic                            cfg_we,
    input  wire logic [lmf_pkg::CFG_INDEX_W-1:0] cfg_index,
    input  wire logic [lmf_pkg::CFG_DATA_W-1:0]  cfg_data,
    lmf_pixel_if.sink                            pix,
    lmf_result_if.source                         res
);

    localparam int WW = $clog2(MAX_WIDTH + 1);
    localparam int CW = $clog2(MAX_WIDTH);
    localparam int LW = $clog2(MAX_WIDTH + 2);
    localparam int HW = lmf_pkg::FRAME_HEIGHT_W;

    logic [lmf_pkg::FRAME_WIDTH_W-1:0] width_reg;
    logic [HW-1:0]                     height_reg;

    logic [CW-1:0] ic_reg;
    logic [HW-1:0] ir_reg;
    logic [CW-1:0] oc_reg;
    logic [HW-1:0] or_reg;
    logic [LW-1:0] lag_reg;

    logic [WW-1:0] w_eff;
    logic [HW-1:0] h_eff;
    logic [CW-1:0] ic_w;
    logic [CW-1:0] oc_w;
    logic [HW-1:0] ir_w;
    logic [HW-1:0] or_w;
    logic [WW-1:0] ic_inc;
    logic [WW-1:0] oc_inc;
    logic          col_end;
    logic          oc_end;
    logic          or_end;
    logic          row_open;
    logic          drop;
    logic          emit;
    logic          last;
    logic [CW-1:0] ic_next;
    logic [HW-1:0] ir_next;
    lmf_pkg::label_t in_label;
    lmf_pkg::edge_t  edges;

    logic            s1_valid_reg;
    logic            s1_emit_reg;
    logic            s1_last_reg;
    lmf_pkg::edge_t  s1_edges_reg;
    lmf_pkg::label_t s1_label_reg;
    logic [CW-1:0]   s1_col_reg;
    logic            s1_byp_reg;
    lmf_pkg::label_t s1_byp_above_reg;
    lmf_pkg::label_t s1_byp_two_reg;

    logic            out_valid_reg;
    lmf_pkg::label_t out_label_reg;
    logic            out_last_reg;

    lmf_pkg::window_t window_reg;
    lmf_pkg::window_t window_next;
    lmf_pkg::window_t shifted;

    logic                     accept;
    logic                     s1_move;
    logic                     take;
    logic [2*lmf_pkg::LABEL_W-1:0] ram_rdata;
    lmf_pkg::label_t          above_eff;
    lmf_pkg::label_t          two_eff;
    lmf_pkg::label_t          vote_label;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            width_reg  <= lmf_pkg::FRAME_WIDTH_RESET;
            height_reg <= lmf_pkg::FRAME_HEIGHT_RESET;
        end
        else if (cfg_we)
        begin
            case (cfg_index)
                lmf_pkg::REG_FRAME_WIDTH:
                begin
                    width_reg <= cfg_data[lmf_pkg::FRAME_WIDTH_W-1:0];
                end
                lmf_pkg::REG_FRAME_HEIGHT:
                begin
                    height_reg <= cfg_data[HW-1:0];
                end
                default:
                begin
                end
            endcase
        end
    end

    always_comb
    begin
        if (width_reg == '0)
        begin
            w_eff = WW'(1);
        end
        else if (32'(width_reg) > 32'(MAX_WIDTH))
        begin
            w_eff = WW'(MAX_WIDTH);
        end
        else
        begin
            w_eff = WW'(width_reg);
        end
        h_eff = (height_reg == '0) ? HW'(1) : height_reg;

        ic_w = (WW'(ic_reg) >= w_eff) ? '0 : ic_reg;
        oc_w = (WW'(oc_reg) >= w_eff) ? '0 : oc_reg;
        ir_w = (ir_reg > h_eff) ? h_eff : ir_reg;
        or_w = (or_reg >= h_eff) ? '0 : or_reg;

        ic_inc  = WW'(ic_w) + WW'(1);
        oc_inc  = WW'(oc_w) + WW'(1);
        col_end = ic_inc >= w_eff;
        oc_end  = oc_inc >= w_eff;
        or_end  = ({1'b0, or_w} + (HW+1)'(1)) >= {1'b0, h_eff};
        last    = or_end && oc_end;

        row_open = ir_w < h_eff;
        drop     = row_open && pix.is_padding;
        emit     = lag_reg >= (LW'(w_eff) + LW'(1));

        ic_next = col_end ? '0 : CW'(ic_inc);
        ir_next = (col_end && row_open) ? ir_w + HW'(1) : ir_w;

        if (32'(pix.pixel_label) >= 32'(lmf_pkg::NUM_CLASSES))
        begin
            in_label = lmf_pkg::LABEL_W'(lmf_pkg::NUM_CLASSES - 1);
        end
        else
        begin
            in_label = pix.pixel_label;
        end

        edges.left   = oc_w != '0;
        edges.right  = !oc_end;
        edges.top    = or_w != '0;
        edges.bottom = !or_end;
    end

    assign take    = !out_valid_reg || res.ready;
    assign s1_move = s1_valid_reg && (!s1_emit_reg || take);
    assign pix.ready = !s1_valid_reg || s1_move;
    assign accept  = pix.valid && pix.ready;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            ic_reg  <= '0;
            ir_reg  <= '0;
            oc_reg  <= '0;
            or_reg  <= '0;
            lag_reg <= '0;
        end
        else if (accept)
        begin
            if (drop)
            begin
                ic_reg <= ic_w;
                ir_reg <= ir_w;
                oc_reg <= oc_w;
                or_reg <= or_w;
            end
            else if (!emit)
            begin
                ic_reg  <= ic_next;
                ir_reg  <= ir_next;
                oc_reg  <= oc_w;
                or_reg  <= or_w;
                lag_reg <= lag_reg + LW'(1);
            end
            else if (last)
            begin
                ic_reg  <= '0;
                ir_reg  <= '0;
                oc_reg  <= '0;
                or_reg  <= '0;
                lag_reg <= '0;
            end
            else
            begin
                ic_reg <= ic_next;
                ir_reg <= ir_next;
                oc_reg <= oc_end ? '0 : CW'(oc_inc);
                or_reg <= oc_end ? or_w + HW'(1) : or_w;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s1_valid_reg <= 1'b0;
        end
        else if (accept)
        begin
            s1_valid_reg <= !drop;
        end
        else if (s1_move)
        begin
            s1_valid_reg <= 1'b0;
        end
    end

    // The word in the read stage writes its column at the same edge at which
    // the next word reads; the bypass registers give such a read the new values.
    always_ff @(posedge clk)
    begin
        if (accept && !drop)
        begin
            s1_emit_reg      <= emit;
            s1_last_reg      <= emit && last;
            s1_edges_reg     <= edges;
            s1_label_reg     <= in_label;
            s1_col_reg       <= ic_w;
            s1_byp_reg       <= s1_valid_reg && (s1_col_reg == ic_w);
            s1_byp_above_reg <= s1_label_reg;
            s1_byp_two_reg   <= above_eff;
        end
    end

    lmf_ram #(
        .WIDTH (2 * lmf_pkg::LABEL_W),
        .DEPTH (MAX_WIDTH)
    ) u_line_ram (
        .clk   (clk),
        .we    (s1_move),
        .waddr (s1_col_reg),
        .wdata ({above_eff, s1_label_reg}),
        .re    (accept && !drop),
        .raddr (ic_w),
        .rdata (ram_rdata)
    );

    always_comb
    begin
        if (s1_byp_reg)
        begin
            above_eff = s1_byp_above_reg;
            two_eff   = s1_byp_two_reg;
        end
        else
        begin
            above_eff = ram_rdata[lmf_pkg::LABEL_W-1:0];
            two_eff   = ram_rdata[2*lmf_pkg::LABEL_W-1:lmf_pkg::LABEL_W];
        end

        shifted[0]    = window_reg[1];
        shifted[1]    = window_reg[2];
        shifted[2][0] = two_eff;
        shifted[2][1] = above_eff;
        shifted[2][2] = s1_label_reg;

        window_next = s1_last_reg ? '0 : shifted;
    end

    lmf_vote u_vote (
        .window (shifted),
        .edges  (s1_edges_reg),
        .label  (vote_label)
    );

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            window_reg <= '0;
        end
        else if (s1_move)
        begin
            window_reg <= window_next;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg <= 1'b0;
        end
        else if (s1_move && s1_emit_reg)
        begin
            out_valid_reg <= 1'b1;
        end
        else if (res.ready)
        begin
            out_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (s1_move && s1_emit_reg)
        begin
            out_label_reg <= vote_label;
            out_last_reg  <= s1_last_reg;
        end
    end

    assign res.valid          = out_valid_reg;
    assign res.smoothed_label = out_label_reg;
    assign res.last_pixel     = out_last_reg;

endmodule
`default_nettype wire
